// ===== hw/rtl/hpq_pkg.sv =====
// Shared definitions for the binary min-heap priority queue.
// Holds port widths, parameter defaults, status and operation codes and the
// controller/datapath command and status structs. No dependencies.
package hpq_pkg;

	// Fixed widths of the item and result fields.
	localparam int PAYLOAD_W  = 32;
	localparam int PRIORITY_W = 16;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 6;

	// Parameter defaults.
	localparam int DEF_CAPACITY      = 63;
	localparam int DEF_PAYLOAD_BITS  = 32;
	localparam int DEF_PRIORITY_BITS = 16;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

	// Operation codes.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept_ins;  // capture the new entry, start position at count+1
		logic accept_rm;   // read root and last slot, start hole at root
		logic ins_rd;      // read the parent of the current position
		logic ins_step;    // move the parent down, climb one level
		logic rm_last;     // capture the root payload and the last entry
		logic rm_rd;       // read both children of the hole
		logic rm_step;     // move the chosen child up, descend one level
		logic fin_ins;     // write the new entry and report
		logic fin_rm;      // write the last entry into the hole and report
		logic rej_full;    // report a rejected insert
		logic rej_empty;   // report a rejected remove
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;        // count equals capacity
		logic empty;       // count is zero
		logic pos_root;    // insert position is the root
		logic ins_less;    // new priority strictly below the parent's
		logic left_out;    // left child of the hole lies beyond the count
		logic down_stop;   // last entry fits at or above the chosen child
	} sts_t;

endpackage

// ===== hw/rtl/hpq_ram.sv =====
// Generic RAM: one write port and two read ports with registered read data.
// Used as the heap store. No dependencies.
module hpq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

// ===== hw/rtl/hpq_ctrl.sv =====
// Controller state machine for the heap: sequences sift-up and sift-down.
// Depends on hpq_pkg for the command and status structs.
module hpq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          operation,
	input  hpq_pkg::sts_t sts,
	output hpq_pkg::cmd_t cmd,
	output logic          busy
);
	import hpq_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_INS_RD  = 3'd1;
	localparam logic [2:0] S_INS_CMP = 3'd2;
	localparam logic [2:0] S_RM_LAST = 3'd3;
	localparam logic [2:0] S_RM_RD   = 3'd4;
	localparam logic [2:0] S_RM_CMP  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (operation == OP_INSERT) begin
						if (sts.full) begin
							cmd.rej_full = 1'b1;
						end else begin
							cmd.accept_ins = 1'b1;
							state_d        = S_INS_RD;
						end
					end else begin
						if (sts.empty) begin
							cmd.rej_empty = 1'b1;
						end else begin
							cmd.accept_rm = 1'b1;
							state_d       = S_RM_LAST;
						end
					end
				end
			end
			S_INS_RD: begin
				if (sts.pos_root) begin
					cmd.fin_ins = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.ins_rd = 1'b1;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (sts.ins_less) begin
					cmd.ins_step = 1'b1;
					state_d      = S_INS_RD;
				end else begin
					cmd.fin_ins = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_RM_LAST: begin
				cmd.rm_last = 1'b1;
				state_d     = S_RM_RD;
			end
			S_RM_RD: begin
				if (sts.left_out) begin
					cmd.fin_rm = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.rm_rd = 1'b1;
					state_d   = S_RM_CMP;
				end
			end
			S_RM_CMP: begin
				if (sts.down_stop) begin
					cmd.fin_rm = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.rm_step = 1'b1;
					state_d     = S_RM_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	// A compare state always follows the read that feeds it.
	a_ins_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_CMP) |-> ($past(state_q) == S_INS_RD))
		else $error("insert compare without a preceding parent read");

	a_rm_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RM_CMP) |-> ($past(state_q) == S_RM_RD))
		else $error("remove compare without a preceding child read");

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command in a cycle");

endmodule

// ===== hw/rtl/hpq_dp.sv =====
// Datapath for the heap: heap store RAM, fill count, position registers,
// comparators and result registers. Depends on hpq_pkg and hpq_ram.
module hpq_dp #(
	parameter int CAPACITY      = hpq_pkg::DEF_CAPACITY,
	parameter int PAYLOAD_BITS  = hpq_pkg::DEF_PAYLOAD_BITS,
	parameter int PRIORITY_BITS = hpq_pkg::DEF_PRIORITY_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [hpq_pkg::PAYLOAD_W-1:0]  payload,
	input  logic [hpq_pkg::PRIORITY_W-1:0] priority_req,
	input  hpq_pkg::cmd_t                  cmd,
	output hpq_pkg::sts_t                  sts,
	output logic                           done,
	output logic [hpq_pkg::PAYLOAD_W-1:0]  removed_payload,
	output logic [hpq_pkg::STATUS_W-1:0]   status,
	output logic                           is_empty,
	output logic [hpq_pkg::COUNT_W-1:0]    entry_count
);
	import hpq_pkg::*;

	localparam int DEPTH = CAPACITY + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = PRIORITY_BITS + PAYLOAD_BITS;

	logic [AW-1:0]            cnt_q;
	logic [AW-1:0]            cnt_d;
	logic [AW-1:0]            pos_q;
	logic [AW-1:0]            hole_q;
	logic [PRIORITY_BITS-1:0] new_pri_q;
	logic [PAYLOAD_BITS-1:0]  new_pay_q;
	logic [PAYLOAD_BITS-1:0]  top_q;
	logic [EW-1:0]            last_q;

	logic                     done_q;
	logic [PAYLOAD_W-1:0]     removed_q;
	logic [STATUS_W-1:0]      status_q;
	logic                     empty_q;
	logic [COUNT_W-1:0]       count_q;

	logic                     we;
	logic [AW-1:0]            waddr;
	logic [EW-1:0]            wdata;
	logic [AW-1:0]            raddr_a;
	logic [AW-1:0]            raddr_b;
	logic [EW-1:0]            rd_a;
	logic [EW-1:0]            rd_b;

	logic [AW:0]              left;
	logic [AW:0]              left_p1;
	logic                     left_eq;
	logic [PRIORITY_BITS-1:0] pri_a;
	logic [PRIORITY_BITS-1:0] pri_b;
	logic [PRIORITY_BITS-1:0] last_pri;
	logic                     pick_b;
	logic [EW-1:0]            pick_ent;
	logic [AW-1:0]            pick_addr;
	logic                     result;

	hpq_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rd_a),
		.raddr_b (raddr_b),
		.rdata_b (rd_b)
	);

	assign left     = {hole_q, 1'b0};
	assign left_p1  = left + (AW + 1)'(1);
	assign left_eq  = (left == {1'b0, cnt_q});
	assign pri_a    = rd_a[EW-1 -: PRIORITY_BITS];
	assign pri_b    = rd_b[EW-1 -: PRIORITY_BITS];
	assign last_pri = last_q[EW-1 -: PRIORITY_BITS];

	// The right child wins only when it exists and is strictly smaller.
	assign pick_b    = !left_eq && (pri_a > pri_b);
	assign pick_ent  = pick_b ? rd_b : rd_a;
	assign pick_addr = pick_b ? left_p1[AW-1:0] : left[AW-1:0];

	assign sts.full      = (cnt_q == AW'(CAPACITY));
	assign sts.empty     = (cnt_q == '0);
	assign sts.pos_root  = (pos_q == AW'(1));
	assign sts.ins_less  = (new_pri_q < pri_a);
	assign sts.left_out  = (left > {1'b0, cnt_q});
	assign sts.down_stop = (last_pri <= pick_ent[EW-1 -: PRIORITY_BITS]);

	always_comb begin
		raddr_a = '0;
		raddr_b = left_eq ? left[AW-1:0] : left_p1[AW-1:0];
		if (cmd.accept_rm) begin
			raddr_a = AW'(1);
			raddr_b = cnt_q;
		end else if (cmd.ins_rd) begin
			raddr_a = pos_q >> 1;
		end else if (cmd.rm_rd) begin
			raddr_a = left[AW-1:0];
		end
	end

	always_comb begin
		we    = cmd.ins_step | cmd.fin_ins | cmd.rm_step | cmd.fin_rm;
		waddr = (cmd.ins_step | cmd.fin_ins) ? pos_q : hole_q;
		wdata = last_q;
		if (cmd.ins_step) begin
			wdata = rd_a;
		end else if (cmd.fin_ins) begin
			wdata = {new_pri_q, new_pay_q};
		end else if (cmd.rm_step) begin
			wdata = pick_ent;
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (cmd.fin_ins) begin
			cnt_d = cnt_q + AW'(1);
		end else if (cmd.fin_rm) begin
			cnt_d = cnt_q - AW'(1);
		end
	end

	assign result = cmd.fin_ins | cmd.fin_rm | cmd.rej_full | cmd.rej_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			done_q <= result;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_ins) begin
			new_pri_q <= PRIORITY_BITS'(priority_req);
			new_pay_q <= PAYLOAD_BITS'(payload);
			pos_q     <= cnt_q + AW'(1);
		end else if (cmd.ins_step) begin
			pos_q <= pos_q >> 1;
		end
		if (cmd.accept_rm) begin
			hole_q <= AW'(1);
		end else if (cmd.rm_step) begin
			hole_q <= pick_addr;
		end
		if (cmd.rm_last) begin
			top_q  <= rd_a[PAYLOAD_BITS-1:0];
			last_q <= rd_b;
		end
		if (result) begin
			removed_q <= cmd.fin_rm ? PAYLOAD_W'(top_q) : '0;
			status_q  <= cmd.rej_full ? STS_FULL : (cmd.rej_empty ? STS_EMPTY : STS_DONE);
			empty_q   <= (cnt_d == '0);
			count_q   <= COUNT_W'(cnt_d);
		end
	end

	assign done            = done_q;
	assign removed_payload = removed_q;
	assign status          = status_q;
	assign is_empty        = empty_q;
	assign entry_count     = count_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= AW'(CAPACITY))
		else $error("fill count beyond capacity");

	a_fin_rm_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_rm |-> (cnt_q != '0))
		else $error("remove completed on an empty heap");

	a_fin_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_ins |-> (cnt_q != AW'(CAPACITY)))
		else $error("insert completed on a full heap");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (empty_q == (cnt_q == '0)))
		else $error("empty flag disagrees with fill count");

endmodule

// ===== hw/rtl/binary_min_heap_priority_queue.sv =====
// Binary min-heap priority queue: top level joining controller and datapath.
// A rejected item is reported straight from idle; an insert or remove makes
// one parent or child-pair read per level of its sift loop before done.
// One item at a time; busy falls in the cycle done is high, so a new start
// may be accepted then. Results cannot be stalled. Reset empties the heap at once.
module binary_min_heap_priority_queue #(
	parameter int CAPACITY      = hpq_pkg::DEF_CAPACITY,
	parameter int PAYLOAD_BITS  = hpq_pkg::DEF_PAYLOAD_BITS,
	parameter int PRIORITY_BITS = hpq_pkg::DEF_PRIORITY_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           operation,
	input  logic [hpq_pkg::PAYLOAD_W-1:0]  payload,
	input  logic [hpq_pkg::PRIORITY_W-1:0] priority_req,
	output logic                           done,
	output logic [hpq_pkg::PAYLOAD_W-1:0]  removed_payload,
	output logic [hpq_pkg::STATUS_W-1:0]   status,
	output logic                           is_empty,
	output logic [hpq_pkg::COUNT_W-1:0]    entry_count
);
	import hpq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	hpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	hpq_dp #(
		.CAPACITY      (CAPACITY),
		.PAYLOAD_BITS  (PAYLOAD_BITS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.payload         (payload),
		.priority_req    (priority_req),
		.cmd             (cmd),
		.sts             (sts),
		.done            (done),
		.removed_payload (removed_payload),
		.status          (status),
		.is_empty        (is_empty),
		.entry_count     (entry_count)
	);

endmodule

// ===== tb/binary_min_heap_priority_queue_test.sv =====
// Self-checking testbench for the binary min-heap priority queue.
// Needs hpq_pkg and the binary_min_heap_priority_queue RTL; a built-in heap
// predictor supplies the expected result of every accepted item.
`timescale 1ns / 1ps

module binary_min_heap_priority_queue_test;

	import hpq_pkg::*;

	localparam int CAP           = DEF_CAPACITY;
	localparam int QUIET_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 20;

	typedef struct packed {
		logic [PAYLOAD_W-1:0] removed_payload;
		logic [STATUS_W-1:0]  status;
		logic                 is_empty;
		logic [COUNT_W-1:0]   entry_count;
	} heap_reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  operation;
	logic [PAYLOAD_W-1:0]  payload;
	logic [PRIORITY_W-1:0] priority_req;
	logic                  done;
	logic [PAYLOAD_W-1:0]  removed_payload;
	logic [STATUS_W-1:0]   status;
	logic                  is_empty;
	logic [COUNT_W-1:0]    entry_count;

	// Predicted heap contents, one-based like the block.
	logic [PRIORITY_W-1:0] heap_key [0:CAP];
	logic [PAYLOAD_W-1:0]  heap_data [0:CAP];
	int                    heap_fill;

	heap_reply_t heap_replies[$];
	int          error_count;
	int          quiet_cycles;

	binary_min_heap_priority_queue dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.payload         (payload),
		.priority_req    (priority_req),
		.done            (done),
		.removed_payload (removed_payload),
		.status          (status),
		.is_empty        (is_empty),
		.entry_count     (entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic heap_reply_t heap_apply(logic op, logic [PAYLOAD_W-1:0] data,
			logic [PRIORITY_W-1:0] key);
		heap_reply_t r;
		int pos;
		int up;
		int hole;
		int left;
		int pick;
		logic [PRIORITY_W-1:0] last_key;
		logic [PAYLOAD_W-1:0]  last_data;
		bit settled;
		r = '0;
		r.status = STS_DONE;
		if (op == OP_INSERT) begin
			if (heap_fill >= CAP) begin
				r.status = STS_FULL;
			end else begin
				pos = heap_fill + 1;
				settled = 0;
				while (pos > 1 && !settled) begin
					up = pos / 2;
					if (key < heap_key[up]) begin
						heap_key[pos]  = heap_key[up];
						heap_data[pos] = heap_data[up];
						pos = up;
					end else begin
						settled = 1;
					end
				end
				heap_key[pos]  = key;
				heap_data[pos] = data;
				heap_fill++;
			end
		end else begin
			if (heap_fill == 0) begin
				r.status = STS_EMPTY;
			end else begin
				r.removed_payload = heap_data[1];
				last_key  = heap_key[heap_fill];
				last_data = heap_data[heap_fill];
				hole = 1;
				settled = 0;
				while (!settled) begin
					left = hole * 2;
					if (left > heap_fill) begin
						settled = 1;
					end else begin
						if (left == heap_fill)
							pick = left;
						else
							pick = (heap_key[left] > heap_key[left+1]) ? left + 1 : left;
						if (last_key <= heap_key[pick]) begin
							settled = 1;
						end else begin
							heap_key[hole]  = heap_key[pick];
							heap_data[hole] = heap_data[pick];
							hole = pick;
						end
					end
				end
				heap_key[hole]  = last_key;
				heap_data[hole] = last_data;
				heap_fill--;
			end
		end
		r.is_empty    = (heap_fill == 0);
		r.entry_count = heap_fill[COUNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		error_count++;
	endtask

	// Results cannot be held off, so each strobe is checked on the edge it is seen.
	always @(posedge clk) begin
		heap_reply_t want;
		if (arst_n && done) begin
			if (heap_replies.size() == 0) begin
				report_mismatch("result with no item pending", removed_payload, 32'd0);
			end else begin
				want = heap_replies.pop_front();
				if (removed_payload !== want.removed_payload)
					report_mismatch("removed_payload", removed_payload, want.removed_payload);
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (is_empty !== want.is_empty)
					report_mismatch("is_empty", is_empty, want.is_empty);
				if (entry_count !== want.entry_count)
					report_mismatch("entry_count", entry_count, want.entry_count);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(logic op, logic [PAYLOAD_W-1:0] data, logic [PRIORITY_W-1:0] key);
		@(negedge clk);
		start        = 1'b1;
		operation    = op;
		payload      = data;
		priority_req = key;
		do @(posedge clk); while (busy);
		heap_replies.push_back(heap_apply(op, data, key));
	endtask

	// Each loop pass waits for a falling clock edge and holds start low.
	task automatic idle_gap(int pct);
		while ($urandom_range(0, 99) < pct) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (heap_replies.size() != 0)
			@(posedge clk);
	endtask

	// Narrow keys give many ties; the extremes are drawn often.
	function automatic logic [PRIORITY_W-1:0] pick_key();
		case ($urandom_range(0, 3))
			0: return PRIORITY_W'($urandom_range(0, 7));
			1: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return PRIORITY_W'(1);
					default: return {PRIORITY_W{1'b1}} - 1'b1;
				endcase
			end
			default: return PRIORITY_W'($urandom);
		endcase
	endfunction

	task automatic test_edge_cases();
		send_item(OP_REMOVE, 32'hDEAD_BEEF, 16'h1234);
		send_item(OP_INSERT, 32'h0000_1234, 16'd5);
		send_item(OP_REMOVE, 32'h0, 16'h0);
		send_item(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		send_item(OP_INSERT, 32'h0000_0000, 16'h0000);
		send_item(OP_INSERT, 32'h0000_0001, 16'h0000);
		send_item(OP_INSERT, 32'hAAAA_5555, 16'd7);
		send_item(OP_INSERT, 32'h5555_AAAA, 16'd7);
		send_item(OP_INSERT, 32'h8000_0000, 16'h8000);
		send_item(OP_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
		repeat (7)
			send_item(OP_REMOVE, $urandom, PRIORITY_W'($urandom));
		send_item(OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
	endtask

	// Filling to capacity reaches the full rejection and the deepest levels.
	task automatic test_fill_and_drain(int idle_pct);
		while (heap_fill < CAP) begin
			idle_gap(idle_pct);
			send_item(OP_INSERT, $urandom, pick_key());
		end
		repeat (2) begin
			idle_gap(idle_pct);
			send_item(OP_INSERT, $urandom, pick_key());
		end
		while (heap_fill > 0) begin
			idle_gap(idle_pct);
			send_item(OP_REMOVE, $urandom, pick_key());
		end
		idle_gap(idle_pct);
		send_item(OP_REMOVE, $urandom, pick_key());
	endtask

	// The fill level drifts up and down between the bounds.
	task automatic test_mixed_traffic(int items, int idle_pct);
		bit climbing;
		logic op;
		climbing = 1;
		repeat (items) begin
			if (heap_fill >= CAP && $urandom_range(0, 3) == 0)
				climbing = 0;
			else if (heap_fill == 0 && $urandom_range(0, 3) == 0)
				climbing = 1;
			op = ($urandom_range(0, 99) < (climbing ? 70 : 30)) ? OP_INSERT : OP_REMOVE;
			idle_gap(idle_pct);
			send_item(op, $urandom, pick_key());
		end
	endtask

	task automatic test_drain_pause();
		repeat (10)
			send_item(OP_INSERT, $urandom, pick_key());
		wait_drained();
		repeat (10)
			send_item(($urandom_range(0, 2) == 0) ? OP_INSERT : OP_REMOVE, $urandom, pick_key());
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		operation    = OP_INSERT;
		payload      = '0;
		priority_req = '0;
		heap_fill    = 0;
		error_count  = 0;
		quiet_cycles = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_edge_cases();
		test_fill_and_drain(0);
		test_mixed_traffic(220, 0);
		test_drain_pause();
		test_fill_and_drain(78);
		test_mixed_traffic(220, 78);
		test_mixed_traffic(220, 12);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
